// File: sv/lrg_pkg.sv
// shared types and constants for the lcg random range generator
`default_nettype none

package lrg_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned SPAN_W   = DATA_W + 1;
   localparam int unsigned ADDR_W   = 4;
   localparam int unsigned MAX_TRIES = 64;
   localparam int unsigned TRY_W    = $clog2(MAX_TRIES);

   localparam logic [DATA_W-1:0] MULT_RESET = 32'd981237;
   localparam logic [DATA_W-1:0] INC_RESET  = 32'd12341234;
   localparam logic [DATA_W-1:0] MOD_RESET  = 32'd2147483647;
   localparam logic [DATA_W-1:0] SEED_RESET = 32'd1;

   // request codes
   localparam logic [1:0] REQ_RAW    = 2'd0;
   localparam logic [1:0] REQ_MOD    = 2'd1;
   localparam logic [1:0] REQ_BUCKET = 2'd2;

   // register indexes
   localparam logic [1:0] REG_MULT = 2'd0;
   localparam logic [1:0] REG_INC  = 2'd1;
   localparam logic [1:0] REG_MOD  = 2'd2;
   localparam logic [1:0] REG_SEED = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BDIV_GO,
      ST_BDIV_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_MOD_GO,
      ST_MOD_WAIT,
      ST_POST,
      ST_RNG_GO,
      ST_RNG_WAIT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: sv/lrg_serial_mul.sv
// bit-serial shift-add multiply-accumulate, low word only
`default_nettype none

module lrg_serial_mul #(
   parameter int unsigned DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] mcand,
   input  wire logic [DATA_W-1:0] mplier,
   input  wire logic [DATA_W-1:0] addend,
   output logic                   done,
   output logic [DATA_W-1:0]      result
);

   localparam int unsigned CNT_W = $clog2(DATA_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = addend;
         a_in    = mcand;
         b_in    = mplier;
      end else if (busy_ff) begin
         // one multiplier bit per cycle
         acc_in = acc_ff + (b_ff[0] ? a_ff : '0);
         a_in   = {a_ff[DATA_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[DATA_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

// File: sv/lrg_serial_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module lrg_serial_div #(
   parameter int unsigned DATA_W = 33
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output logic                   done,
   output logic [DATA_W-1:0]      quotient,
   output logic [DATA_W-1:0]      remainder
);

   localparam int unsigned CNT_W = $clog2(DATA_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so it fits the word
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: sv/lcg_random_range_generator.sv
// top level: lcg random number generator with ranged and bucketed draws
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_type, req_range_max
//   rsp       out        rsp_valid/rsp_stall  rsp_value, rsp_range_error
//   csr       in/out     apb-style            multiplier, increment, modulus, seed
//
// one request at a time. each lcg step runs the serial multiplier and then the
// serial divider for the modulus reduction (no divide when the modulus is 0).
// a ranged reduction or the bucket size divide adds one more serial divide.
// a bucketed draw repeats the lcg step up to 64 times.
// reset is synchronous and loads the register defaults and the idle state.
// a finished result waits in the output register while the next request is taken.
`default_nettype none

module lcg_random_range_generator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_type,
   input  wire logic [lrg_pkg::DATA_W-1:0]  req_range_max,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [lrg_pkg::DATA_W-1:0]       rsp_value,
   output logic                             rsp_range_error,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [lrg_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [lrg_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [lrg_pkg::DATA_W-1:0]       csr_prdata,
   output logic                             csr_pready
);

   import lrg_pkg::*;

   state_type state_ff, state_in;

   logic [DATA_W-1:0] mult_ff, inc_ff, mod_ff, seed_ff, lcg_ff;
   logic [1:0]        type_ff;
   logic [DATA_W-1:0] rmax_ff;
   logic [SPAN_W-1:0] bsize_ff;
   logic [TRY_W-1:0]  tries_ff;
   logic [DATA_W-1:0] res_ff;
   logic              err_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_err_ff;

   logic              req_take;
   logic              cfg_write;
   logic [1:0]        cfg_index;
   logic              mod_zero;
   logic [SPAN_W-1:0] span;
   logic              in_ranged;
   logic              in_bad;
   logic              rsp_load;
   logic              is_mod_req;
   logic              is_bucket_req;
   logic              q_ok;
   logic              give_up;

   logic              mul_start, mul_done;
   logic [DATA_W-1:0] mul_result;
   logic              div_start, div_done;
   logic [SPAN_W-1:0] div_dividend, div_divisor, div_quot, div_rem;

   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_index = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   // modulus 0 stands for the full 2^32 span
   assign mod_zero = (mod_ff == '0);
   assign span     = {mod_zero, mod_ff};

   assign req_take  = req_valid && !req_stall;
   assign in_ranged = (req_type == REQ_MOD) || (req_type == REQ_BUCKET);
   assign in_bad    = (req_range_max == '0) || ({1'b0, req_range_max} > span);

   assign is_mod_req    = (type_ff == REQ_MOD);
   assign is_bucket_req = (type_ff == REQ_BUCKET);
   assign q_ok    = (div_quot < {1'b0, rmax_ff});
   assign give_up = (tries_ff == TRY_W'(MAX_TRIES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (in_ranged && in_bad) state_in = ST_DONE;
               else if (req_type == REQ_BUCKET) state_in = ST_BDIV_GO;
               else state_in = ST_MUL_GO;
            end
         end
         ST_BDIV_GO:   state_in = ST_BDIV_WAIT;
         ST_BDIV_WAIT: if (div_done) state_in = ST_MUL_GO;
         ST_MUL_GO:    state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mul_done) state_in = mod_zero ? ST_POST : ST_MOD_GO;
         end
         ST_MOD_GO:    state_in = ST_MOD_WAIT;
         ST_MOD_WAIT:  if (div_done) state_in = ST_POST;
         ST_POST: begin
            if (is_mod_req || is_bucket_req) state_in = ST_RNG_GO;
            else state_in = ST_DONE;
         end
         ST_RNG_GO:    state_in = ST_RNG_WAIT;
         ST_RNG_WAIT: begin
            if (div_done) begin
               if (is_mod_req || q_ok || give_up) state_in = ST_DONE;
               else state_in = ST_MUL_GO;
            end
         end
         ST_DONE:      if (rsp_load) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      mul_start    = (state_ff == ST_MUL_GO);
      div_start    = 1'b0;
      div_dividend = {1'b0, lcg_ff};
      div_divisor  = {1'b0, rmax_ff};
      rsp_load     = 1'b0;
      case (state_ff)
         ST_BDIV_GO: begin
            div_start    = 1'b1;
            div_dividend = span;
            div_divisor  = {1'b0, rmax_ff};
         end
         ST_MOD_GO: begin
            div_start    = 1'b1;
            div_dividend = {1'b0, mul_result};
            div_divisor  = {1'b0, mod_ff};
         end
         ST_RNG_GO: begin
            div_start    = 1'b1;
            div_dividend = {1'b0, lcg_ff};
            div_divisor  = is_mod_req ? {1'b0, rmax_ff} : bsize_ff;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   lrg_serial_mul #(
      .DATA_W (DATA_W)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (lcg_ff),
      .mplier (mult_ff),
      .addend (inc_ff),
      .done   (mul_done),
      .result (mul_result)
   );

   lrg_serial_div #(
      .DATA_W (SPAN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // control state, configuration and lcg state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mult_ff      <= MULT_RESET;
         inc_ff       <= INC_RESET;
         mod_ff       <= MOD_RESET;
         seed_ff      <= SEED_RESET;
         lcg_ff       <= SEED_RESET;
         tries_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_write) begin
            case (cfg_index)
               REG_MULT: mult_ff <= csr_pwdata;
               REG_INC:  inc_ff  <= csr_pwdata;
               REG_MOD:  mod_ff  <= csr_pwdata;
               REG_SEED: begin
                  seed_ff <= csr_pwdata;
                  lcg_ff  <= csr_pwdata;
               end
               default:  mult_ff <= mult_ff;
            endcase
         end else if (state_ff == ST_MUL_WAIT && mul_done && mod_zero) begin
            lcg_ff <= mul_result;
         end else if (state_ff == ST_MOD_WAIT && div_done) begin
            lcg_ff <= div_rem[DATA_W-1:0];
         end
         if (req_take) begin
            tries_ff <= '0;
         end else if (state_ff == ST_RNG_WAIT && div_done) begin
            tries_ff <= tries_ff + 1'b1;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         type_ff <= req_type;
         rmax_ff <= req_range_max;
         err_ff  <= in_ranged && in_bad;
         res_ff  <= '0;
      end
      if (state_ff == ST_BDIV_WAIT && div_done) bsize_ff <= div_quot;
      if (state_ff == ST_POST) res_ff <= lcg_ff;
      if (state_ff == ST_RNG_WAIT && div_done) begin
         if (is_mod_req) res_ff <= div_rem[DATA_W-1:0];
         else if (q_ok) res_ff <= div_quot[DATA_W-1:0];
         else res_ff <= rmax_ff - 1'b1;
      end
      if (rsp_load) begin
         rsp_value_ff <= res_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   always_comb begin
      case (cfg_index)
         REG_MULT: csr_prdata = mult_ff;
         REG_INC:  csr_prdata = inc_ff;
         REG_MOD:  csr_prdata = mod_ff;
         REG_SEED: csr_prdata = seed_ff;
         default:  csr_prdata = '0;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

`default_nettype wire
